>>> src/loc_pkg.sv
`default_nettype none

package loc_pkg;

  // Reset value of the debounce register.
  localparam logic [15:0] DebounceReset = 16'd200;

  // Configuration port sizing: one 32-bit register at byte address 0.
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // Index of the debounce register in the register map.
  localparam logic RegDebounce = 1'b0;

  typedef enum logic [2:0] {
    ActStart   = 3'd0,
    ActClaim   = 3'd1,
    ActRelease = 3'd2,
    ActEdge    = 3'd3,
    ActTick    = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ModeUnknown     = 3'd0,
    ModeSupport     = 3'd1,
    ModeUnclaimed   = 3'd2,
    ModeClaimPend   = 3'd3,
    ModeClaimed     = 3'd4,
    ModeReleasePend = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StStore   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StoreNone  = 2'd0,
    StoreOwner = 2'd1,
    StoreNull  = 2'd2
  } store_wr_e;

  // One request item.
  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] uuid_upper;
    logic [63:0] uuid_lower;
    logic        position;
    logic        store_ok;
  } loc_in_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  lock_state;
    logic        alarm;
    logic        open_cmd;
    logic        close_cmd;
    logic [1:0]  store_write;
    logic [63:0] owner_upper;
    logic [63:0] owner_lower;
  } loc_out_t;

endpackage

`default_nettype wire

>>> src/loc_cfg.sv
`default_nettype none

module loc_cfg import loc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output logic      [15:0]      debounce_o
);

  logic [15:0] debounce_q;
  logic [15:0] debounce_d;
  logic        sel_debounce;
  logic        wr_en;

  // Register index is the word address.
  assign sel_debounce = (paddr[2] == RegDebounce);
  assign wr_en        = psel && penable && pwrite && pready;

  always_comb begin
    debounce_d = debounce_q;
    if (wr_en && sel_debounce) begin
      debounce_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
    end else begin
      debounce_q <= debounce_d;
    end
  end

  // Reads return the register, zero elsewhere.
  assign prdata     = sel_debounce ? {16'd0, debounce_q} : '0;
  assign pready     = 1'b1;
  assign debounce_o = debounce_q;

endmodule

`default_nettype wire

>>> src/loc_core.sv
`default_nettype none

module loc_core import loc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire loc_in_t     req_i,
  input  wire logic [15:0] debounce_i,
  output loc_out_t         res_o
);

  mode_e       mode_q, mode_d;
  logic [63:0] owner_hi_q, owner_hi_d;
  logic [63:0] owner_lo_q, owner_lo_d;
  logic        alarm_q, alarm_d;
  logic [31:0] tick_q, tick_d;
  logic [31:0] last_q, last_d;

  status_e     status;
  store_wr_e   store_wr;
  logic        open_cmd;
  logic        close_cmd;
  logic        id_null;
  logic        id_match;
  logic [31:0] elapsed;
  logic        debounced;

  assign id_null   = (req_i.uuid_upper == 64'd0) && (req_i.uuid_lower == 64'd0);
  assign id_match  = (owner_hi_q == req_i.uuid_upper) && (owner_lo_q == req_i.uuid_lower);
  assign elapsed   = tick_q - last_q;
  assign debounced = (elapsed >= {16'd0, debounce_i});

  // Next state and result for the request in the input register.
  always_comb begin
    mode_d     = mode_q;
    owner_hi_d = owner_hi_q;
    owner_lo_d = owner_lo_q;
    alarm_d    = alarm_q;
    tick_d     = tick_q;
    last_d     = last_q;
    status     = StOk;
    store_wr   = StoreNone;
    open_cmd   = 1'b0;
    close_cmd  = 1'b0;
    case (action_e'(req_i.action))
      ActStart: begin
        if (mode_q != ModeUnknown) begin
          status = StInvalid;
        end else begin
          last_d = tick_q;
          if (!req_i.store_ok) begin
            mode_d = ModeSupport;
            status = StStore;
          end else begin
            owner_hi_d = req_i.uuid_upper;
            owner_lo_d = req_i.uuid_lower;
            if (id_null) begin
              mode_d = ModeUnclaimed;
            end else if (req_i.position) begin
              mode_d = ModeClaimed;
            end else begin
              mode_d  = ModeSupport;
              alarm_d = 1'b1;
              status  = StInvalid;
            end
          end
        end
      end
      ActClaim: begin
        if (mode_q == ModeUnclaimed) begin
          mode_d     = ModeClaimPend;
          owner_hi_d = req_i.uuid_upper;
          owner_lo_d = req_i.uuid_lower;
          open_cmd   = req_i.position;
        end else begin
          status = StInvalid;
        end
      end
      ActRelease: begin
        if (mode_q == ModeClaimed && id_match) begin
          mode_d   = ModeReleasePend;
          open_cmd = req_i.position;
        end else begin
          status = StInvalid;
        end
      end
      ActEdge: begin
        last_d = tick_q;
        if (debounced) begin
          if (mode_q == ModeClaimPend) begin
            if (req_i.position) begin
              close_cmd = 1'b1;
              store_wr  = StoreOwner;
              if (req_i.store_ok) begin
                mode_d = ModeClaimed;
              end else begin
                open_cmd = 1'b1;
                status   = StStore;
              end
            end
          end else if (mode_q == ModeClaimed) begin
            alarm_d = !req_i.position;
          end else if (mode_q == ModeReleasePend) begin
            if (!req_i.position) begin
              store_wr = StoreNull;
              if (req_i.store_ok) begin
                owner_hi_d = 64'd0;
                owner_lo_d = 64'd0;
                mode_d     = ModeUnclaimed;
              end else begin
                status = StStore;
              end
            end
          end
        end
      end
      ActTick: begin
        tick_d = tick_q + 32'd1;
      end
      default: begin
      end
    endcase
  end

  // Result fields reflect the state after the step.
  always_comb begin
    res_o.status      = status;
    res_o.lock_state  = mode_d;
    res_o.alarm       = alarm_d;
    res_o.open_cmd    = open_cmd;
    res_o.close_cmd   = close_cmd;
    res_o.store_write = store_wr;
    res_o.owner_upper = owner_hi_d;
    res_o.owner_lower = owner_lo_d;
  end

  // State registers advance once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeUnknown;
      owner_hi_q <= 64'd0;
      owner_lo_q <= 64'd0;
      alarm_q    <= 1'b0;
      tick_q     <= 32'd0;
      last_q     <= 32'd0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      owner_hi_q <= owner_hi_d;
      owner_lo_q <= owner_lo_d;
      alarm_q    <= alarm_d;
      tick_q     <= tick_d;
      last_q     <= last_d;
    end
  end

endmodule

`default_nettype wire

>>> src/lock_ownership_controller.sv
// A request passes through the input register, then the result register.
// Throughput: one request per cycle while out_ready_i keeps the result register draining;
// the state update is a single compare-and-select step.
// Reset (rst_ni low, asynchronous): mode unknown, null owner, alarm and counters clear,
// debounce register 200, both pipeline registers empty.
`default_nettype none

module lock_ownership_controller import loc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire loc_in_t          in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output loc_out_t              out_res_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  logic        in_valid_q;
  loc_in_t     in_req_q;
  logic        out_valid_q;
  loc_out_t    out_res_q;
  loc_out_t    core_res;
  logic        advance;
  logic [15:0] debounce;

  loc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .debounce_o (debounce)
  );

  // The buffered request moves on when the result register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  loc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .req_i      (in_req_q),
    .debounce_i (debounce),
    .res_o      (core_res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_req_q <= in_req_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

`default_nettype wire

>>> tb/lock_ownership_controller_test.sv
`default_nettype none

module lock_ownership_controller_test;
  import loc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Action code outside the defined set; the block must leave its state alone.
  localparam logic [2:0] ActSpare = 3'd7;
  localparam logic [AddrW-1:0] DebounceAddr = AddrW'(4 * int'(RegDebounce));
  localparam int NoWrite = -1;
  localparam int NumPhases = 5;
  localparam int PhaseItems = 270;
  localparam int HoldCycles = 300;
  // The longest legal quiet stretch is the receiver hold-off plus a random stall.
  localparam int QuietLimit = 3000;
  localparam int MaxPrinted = 30;

  // One row of the directed table: an optional debounce write before the request,
  // the request itself, and an expected result where it is typed in by hand.
  typedef struct {
    int       dbnc;
    loc_in_t  req;
    bit       typed;
    loc_out_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        req_valid = 1'b0;
  logic        req_ready;
  loc_in_t     req_data = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  loc_out_t    res_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic        pready;

  // Predicted controller state and configuration.
  mode_e       lk_mode;
  logic [63:0] lk_owner_hi;
  logic [63:0] lk_owner_lo;
  logic        lk_alarm;
  logic [31:0] lk_ticks;
  logic [31:0] lk_last_edge;
  logic [15:0] lk_debounce;

  loc_out_t    pending_results[$];
  dir_row_t    dir_rows[$];

  int          err_count = 0;
  int          req_count = 0;
  int          res_count = 0;
  int          dbnc_writes = 0;
  int          alarm_results = 0;
  int          store_fails = 0;
  logic [5:0]  seen_modes = '0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          quiet = 0;

  int unsigned phase_dbnc [NumPhases] = '{0, 3, 1, 16, 0};
  int          phase_send [NumPhases] = '{0, 46, 0, 28, 0};
  int          phase_recv [NumPhases] = '{0, 0, 46, 28, 0};

  lock_ownership_controller uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_req_i   (req_data),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .out_res_o  (res_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic loc_in_t mk_req(input logic [2:0] act, input logic [63:0] hi,
                                     input logic [63:0] lo, input logic pos,
                                     input logic ok);
    loc_in_t rq;
    rq.action = act;
    rq.uuid_upper = hi;
    rq.uuid_lower = lo;
    rq.position = pos;
    rq.store_ok = ok;
    return rq;
  endfunction

  function automatic loc_out_t mk_res(input status_e st, input mode_e md, input logic al,
                                      input logic op, input logic cl, input store_wr_e sw,
                                      input logic [63:0] hi, input logic [63:0] lo);
    loc_out_t r;
    r.status = st;
    r.lock_state = md;
    r.alarm = al;
    r.open_cmd = op;
    r.close_cmd = cl;
    r.store_write = sw;
    r.owner_upper = hi;
    r.owner_lower = lo;
    return r;
  endfunction

  // Advance the predicted controller by one request and return its result.
  function automatic loc_out_t next_lock_result(input loc_in_t rq);
    loc_out_t    r;
    logic [31:0] elapsed;
    r = '0;
    r.status = StOk;
    r.store_write = StoreNone;
    case (rq.action)
      ActStart: begin
        if (lk_mode != ModeUnknown) begin
          r.status = StInvalid;
        end else begin
          lk_last_edge = lk_ticks;
          if (!rq.store_ok) begin
            lk_mode = ModeSupport;
            r.status = StStore;
          end else begin
            lk_owner_hi = rq.uuid_upper;
            lk_owner_lo = rq.uuid_lower;
            if (rq.uuid_upper == '0 && rq.uuid_lower == '0) begin
              lk_mode = ModeUnclaimed;
            end else if (rq.position) begin
              lk_mode = ModeClaimed;
            end else begin
              lk_mode = ModeSupport;
              lk_alarm = 1'b1;
              r.status = StInvalid;
            end
          end
        end
      end
      ActClaim: begin
        if (lk_mode == ModeUnclaimed) begin
          lk_mode = ModeClaimPend;
          lk_owner_hi = rq.uuid_upper;
          lk_owner_lo = rq.uuid_lower;
          r.open_cmd = rq.position;
        end else begin
          r.status = StInvalid;
        end
      end
      ActRelease: begin
        if (lk_mode == ModeClaimed && lk_owner_hi == rq.uuid_upper &&
            lk_owner_lo == rq.uuid_lower) begin
          lk_mode = ModeReleasePend;
          r.open_cmd = rq.position;
        end else begin
          r.status = StInvalid;
        end
      end
      ActEdge: begin
        // The edge time is always recorded; the edge only acts once debounced.
        elapsed = lk_ticks - lk_last_edge;
        lk_last_edge = lk_ticks;
        if (elapsed >= 32'(lk_debounce)) begin
          case (lk_mode)
            ModeClaimPend: begin
              if (rq.position) begin
                r.close_cmd = 1'b1;
                r.store_write = StoreOwner;
                if (rq.store_ok) begin
                  lk_mode = ModeClaimed;
                end else begin
                  r.open_cmd = 1'b1;
                  r.status = StStore;
                end
              end
            end
            ModeClaimed: lk_alarm = ~rq.position;
            ModeReleasePend: begin
              if (!rq.position) begin
                r.store_write = StoreNull;
                if (rq.store_ok) begin
                  lk_owner_hi = '0;
                  lk_owner_lo = '0;
                  lk_mode = ModeUnclaimed;
                end else begin
                  r.status = StStore;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ActTick: lk_ticks = lk_ticks + 32'd1;
      default: ;
    endcase
    r.lock_state = lk_mode;
    r.alarm = lk_alarm;
    r.owner_upper = lk_owner_hi;
    r.owner_lower = lk_owner_lo;
    return r;
  endfunction

  // Choose the next random request: mostly the step the current state is waiting
  // for, with random IDs and outcomes, and some fully random noise.
  function automatic loc_in_t pick_request();
    loc_in_t      rq;
    logic [31:0]  elapsed;
    logic         due;
    logic [127:0] id;
    int           roll;
    roll = $urandom_range(0, 99);
    elapsed = lk_ticks - lk_last_edge;
    due = (elapsed >= 32'(lk_debounce));
    rq.action = ActTick;
    rq.uuid_upper = {$urandom, $urandom};
    rq.uuid_lower = {$urandom, $urandom};
    rq.position = 1'($urandom_range(0, 1));
    rq.store_ok = 1'($urandom_range(0, 1));
    if (roll < 12) begin
      rq.action = 3'($urandom_range(0, 7));
      return rq;
    end
    case (lk_mode)
      ModeUnclaimed: begin
        rq.action = ActClaim;
        if (roll < 20) begin
          rq.uuid_upper = '0;
          rq.uuid_lower = '0;
        end
      end
      ModeClaimPend: begin
        if (due) begin
          rq.action = ActEdge;
          rq.position = (roll < 80);
          rq.store_ok = ($urandom_range(0, 99) < 80);
        end
      end
      ModeClaimed: begin
        if (roll < 55) begin
          rq.action = ActRelease;
          id = {lk_owner_hi, lk_owner_lo};
          // A near miss: the requester differs from the owner in one bit.
          if (roll >= 45) id = id ^ (128'd1 << $urandom_range(0, 127));
          {rq.uuid_upper, rq.uuid_lower} = id;
        end else if (due) begin
          rq.action = ActEdge;
        end
      end
      ModeReleasePend: begin
        if (due) begin
          rq.action = ActEdge;
          rq.position = (roll >= 75);
          rq.store_ok = ($urandom_range(0, 99) < 80);
        end
      end
      default: rq.action = 3'($urandom_range(0, 7));
    endcase
    return rq;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MaxPrinted) $display("MISMATCH at result %0d: %s", res_count, msg);
  endtask

  // Offer one request, with random idle cycles first, and record its expected
  // result once it is accepted. Called just after a rising edge.
  task automatic push_request(input loc_in_t rq, input bit typed, input loc_out_t fixed);
    loc_out_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= rq;
    do @(posedge clk); while (!req_ready);
    want = next_lock_result(rq);
    if (typed) want = fixed;
    pending_results.push_back(want);
    req_count++;
    seen_modes[lk_mode] = 1'b1;
    if (want.alarm) alarm_results++;
    if (want.status == StStore) store_fails++;
  endtask

  // Stop offering requests and wait until every expected result has come.
  task automatic settle();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write of the debounce register: setup cycle, then access until pready.
  task automatic write_debounce(input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DebounceAddr;
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    lk_debounce = value;
    dbnc_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Receiver: random stalls per phase, and a long hold-off on request.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin
    loc_out_t want;
    if (rst_n && res_valid && res_ready) begin
      res_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (res_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", res_data.status, want.status));
        if (res_data.lock_state !== want.lock_state)
          report_mismatch($sformatf("lock_state got %0d want %0d",
                                    res_data.lock_state, want.lock_state));
        if (res_data.alarm !== want.alarm)
          report_mismatch($sformatf("alarm got %b want %b", res_data.alarm, want.alarm));
        if (res_data.open_cmd !== want.open_cmd)
          report_mismatch($sformatf("open_cmd got %b want %b",
                                    res_data.open_cmd, want.open_cmd));
        if (res_data.close_cmd !== want.close_cmd)
          report_mismatch($sformatf("close_cmd got %b want %b",
                                    res_data.close_cmd, want.close_cmd));
        if (res_data.store_write !== want.store_write)
          report_mismatch($sformatf("store_write got %0d want %0d",
                                    res_data.store_write, want.store_write));
        if (res_data.owner_upper !== want.owner_upper)
          report_mismatch($sformatf("owner_upper got %h want %h",
                                    res_data.owner_upper, want.owner_upper));
        if (res_data.owner_lower !== want.owner_lower)
          report_mismatch($sformatf("owner_lower got %h want %h",
                                    res_data.owner_lower, want.owner_lower));
      end
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (res_valid && res_ready) || (psel && penable)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("Watchdog expired after %0d quiet cycles, %0d results still due.",
                 QuietLimit, pending_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    loc_in_t  rq;
    int       counted;
    bit       hold_done;
    bit       pause_done;
    logic [63:0] ones;
    logic [63:0] tag;

    ones = '1;
    tag = 64'h0123_4567_89ab_cdef;
    hold_done = 1'b0;
    pause_done = 1'b0;
    phase_dbnc[NumPhases-1] = $urandom_range(0, 6);

    // Predictor starts from the reset state.
    lk_mode = ModeUnknown;
    lk_owner_hi = '0;
    lk_owner_lo = '0;
    lk_alarm = 1'b0;
    lk_ticks = '0;
    lk_last_edge = '0;
    lk_debounce = DebounceReset;

    // Directed table. Before the start event everything is refused or ignored;
    // then the start loads an all-ones owner with the lock closed.
    dir_rows.push_back('{NoWrite, mk_req(ActClaim, '0, '0, 1'b1, 1'b1), 1'b1,
        mk_res(StInvalid, ModeUnknown, 1'b0, 1'b0, 1'b0, StoreNone, '0, '0)});
    dir_rows.push_back('{NoWrite, mk_req(ActRelease, '0, '0, 1'b1, 1'b0), 1'b1,
        mk_res(StInvalid, ModeUnknown, 1'b0, 1'b0, 1'b0, StoreNone, '0, '0)});
    dir_rows.push_back('{NoWrite, mk_req(ActEdge, '0, '0, 1'b1, 1'b1), 1'b1,
        mk_res(StOk, ModeUnknown, 1'b0, 1'b0, 1'b0, StoreNone, '0, '0)});
    dir_rows.push_back('{NoWrite, mk_req(ActTick, ones, ones, 1'b0, 1'b0), 1'b1,
        mk_res(StOk, ModeUnknown, 1'b0, 1'b0, 1'b0, StoreNone, '0, '0)});
    dir_rows.push_back('{NoWrite, mk_req(ActSpare, ones, ones, 1'b1, 1'b1), 1'b1,
        mk_res(StOk, ModeUnknown, 1'b0, 1'b0, 1'b0, StoreNone, '0, '0)});
    dir_rows.push_back('{NoWrite, mk_req(ActStart, ones, ones, 1'b1, 1'b1), 1'b1,
        mk_res(StOk, ModeClaimed, 1'b0, 1'b0, 1'b0, StoreNone, ones, ones)});
    dir_rows.push_back('{NoWrite, mk_req(ActStart, '0, '0, 1'b1, 1'b1), 1'b1,
        mk_res(StInvalid, ModeClaimed, 1'b0, 1'b0, 1'b0, StoreNone, ones, ones)});
    dir_rows.push_back('{NoWrite, mk_req(ActRelease, ones, '0, 1'b1, 1'b1), 1'b1,
        mk_res(StInvalid, ModeClaimed, 1'b0, 1'b0, 1'b0, StoreNone, ones, ones)});
    // An open edge right after the start falls inside the reset debounce window.
    dir_rows.push_back('{NoWrite, mk_req(ActEdge, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{NoWrite, mk_req(ActTick, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{NoWrite, mk_req(ActRelease, ones, ones, 1'b1, 1'b0), 1'b0, '0});
    // With no debounce: wrong position, failed null save, then a good release.
    dir_rows.push_back('{0, mk_req(ActEdge, '0, '0, 1'b1, 1'b1), 1'b0, '0});
    dir_rows.push_back('{NoWrite, mk_req(ActEdge, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{NoWrite, mk_req(ActEdge, '0, '0, 1'b0, 1'b1), 1'b0, '0});
    dir_rows.push_back('{NoWrite, mk_req(ActRelease, '0, '0, 1'b0, 1'b1), 1'b0, '0});
    // Claim cycle: open claim, repeated claim, failed and good owner saves.
    dir_rows.push_back('{NoWrite, mk_req(ActClaim, tag, '0, 1'b0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{NoWrite, mk_req(ActClaim, ones, ones, 1'b1, 1'b1), 1'b0, '0});
    dir_rows.push_back('{NoWrite, mk_req(ActEdge, '0, '0, 1'b0, 1'b1), 1'b0, '0});
    dir_rows.push_back('{NoWrite, mk_req(ActEdge, '0, '0, 1'b1, 1'b0), 1'b0, '0});
    dir_rows.push_back('{NoWrite, mk_req(ActEdge, '0, '0, 1'b1, 1'b1), 1'b0, '0});
    // Tamper while claimed raises the alarm.
    dir_rows.push_back('{NoWrite, mk_req(ActEdge, '0, '0, 1'b0, 1'b1), 1'b0, '0});
    // Largest debounce: the closing edge is filtered and the alarm stays up.
    dir_rows.push_back('{65535, mk_req(ActEdge, '0, '0, 1'b1, 1'b1), 1'b0, '0});
    dir_rows.push_back('{NoWrite, mk_req(ActRelease, tag, '0, 1'b0, 1'b1), 1'b0, '0});
    dir_rows.push_back('{NoWrite, mk_req(ActTick, ones, ones, 1'b1, 1'b1), 1'b0, '0});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].dbnc != NoWrite) begin
        settle();
        write_debounce(16'(dir_rows[i].dbnc));
      end
      push_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random phases, each with its own debounce setting and idling pattern.
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      write_debounce(16'(phase_dbnc[ph]));
      send_idle_pct = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      counted = 0;
      while (counted < PhaseItems) begin
        rq = pick_request();
        push_request(rq, 1'b0, '0);
        if (rq.action <= ActTick) counted++;
        // Long receiver hold-off while requests keep coming, so the block backs up.
        if (ph == 2 && counted >= 40 && !hold_done) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        // Sender pause until the block has delivered everything.
        if (ph == 3 && counted >= 100 && !pause_done) begin
          req_valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
          pause_done = 1'b1;
        end
      end
    end

    settle();
    repeat (4) @(posedge clk);

    $display("Run covered %0d requests and %0d checked results over %0d debounce settings.",
             req_count, res_count, dbnc_writes);
    $display("Lock states reached (one bit per state): %b; alarm high in %0d results, %0d store failures.",
             seen_modes, alarm_results, store_fails);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
src/loc_pkg.sv
src/loc_cfg.sv
src/loc_core.sv
src/lock_ownership_controller.sv
tb/lock_ownership_controller_test.sv
